### design/imac_pkg.sv
// Shared constants, types and helper functions of the image moment accumulator.
package imac_pkg;

  localparam int MAX_DIM        = 1024;
  localparam int MAX_ORDER      = 3;
  localparam int MEAN_FRAC_BITS = 8;

  // Fixed field widths
  localparam int GREY_W    = 8;
  localparam int MOMENT_W  = 64;
  localparam int STATUS_W  = 2;
  localparam int CFG_ORD_W = 2;
  localparam int CFG_DIM_W = 11;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(1024);

  // Derived widths
  localparam int COORD_W  = $clog2(MAX_DIM);
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int ORD_W    = $clog2(MAX_ORDER + 1);
  localparam int MEAN_W   = COORD_W + MEAN_FRAC_BITS;
  localparam int FAC_W    = MEAN_W;
  localparam int SUM_G_W  = 2 * COORD_W + GREY_W;
  localparam int SUM_RC_W = 3 * COORD_W + GREY_W;
  localparam int DIVD_W   = SUM_RC_W + MEAN_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  // Wide product held as 32-bit limbs
  localparam int LIMB_W     = 32;
  localparam int PROD_W     = FAC_W * 2 * MAX_ORDER + GREY_W;
  localparam int LIMBS_RAW  = (PROD_W + LIMB_W - 1) / LIMB_W;
  localparam int LIMBS      = (LIMBS_RAW < 2) ? 2 : LIMBS_RAW;
  localparam int LIMB_IDX_W = $clog2(LIMBS);
  localparam int PROD_BITS  = LIMBS * LIMB_W;
  localparam int SH_W       = $clog2(MEAN_FRAC_BITS * 2 * MAX_ORDER + 2);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORDER_ROW = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORDER_COL = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  localparam logic signed [MOMENT_W-1:0] MOM_MAX = {1'b0, {(MOMENT_W-1){1'b1}}};
  localparam logic signed [MOMENT_W-1:0] MOM_MIN = {1'b1, {(MOMENT_W-1){1'b0}}};

  typedef struct packed {
    logic [GREY_W-1:0]  grey;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } pix_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_ACC,
    BK_FEND,
    BK_DIV_ROW,
    BK_DIV_COL,
    BK_EMIT
  } bk_state_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0 || v32 > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(v32);
  endfunction

  function automatic logic [ORD_W-1:0] eff_order(input logic [CFG_ORD_W-1:0] v);
    if (32'(v) > 32'(MAX_ORDER)) begin
      return ORD_W'(MAX_ORDER);
    end
    return ORD_W'(v);
  endfunction

endpackage

### design/imac_fifo.sv
// Short item queue between the pixel front end and the moment engine.
module imac_fifo import imac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  logic      push,
  input  pix_item_t push_item,
  output logic      full,
  input  logic      pop,
  output pix_item_t pop_item,
  output logic      empty
);

  pix_item_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   count_r;

  assign full     = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### design/imac_front.sv
// Pixel front end: takes pixels, tracks raster position and marks the pass end.
module imac_front import imac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [GREY_W-1:0]    in_grey,
  input  logic [CFG_DIM_W-1:0] image_width,
  input  logic [CFG_DIM_W-1:0] image_height,
  input  logic                 q_full,
  output logic                 q_push,
  output pix_item_t            q_item
);

  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic               col_last;
  logic               row_last;

  assign col_last = ((DIM_W'(col_r) + 1'b1) == eff_dim(image_width));
  assign row_last = ((DIM_W'(row_r) + 1'b1) == eff_dim(image_height));

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign q_item.grey = in_grey;
  assign q_item.row  = row_r;
  assign q_item.col  = col_r;
  assign q_item.last = col_last && row_last;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

endmodule

### design/imac_div.sv
// Restoring divider, one quotient bit per cycle, for the fixed-point means.
module imac_div import imac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DIVD_W-1:0]   dividend,
  input  logic [SUM_G_W-1:0]  divisor,
  output logic                done,
  output logic [MEAN_W-1:0]   quotient
);

  logic [SUM_G_W-1:0]   rem_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [SUM_G_W-1:0]   div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [SUM_G_W:0]     rem_sh;
  logic                 ge;

  assign rem_sh   = {rem_r, quo_r[DIVD_W-1]};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign done     = done_r;
  assign quotient = quo_r[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? SUM_G_W'(rem_sh - {1'b0, div_r}) : SUM_G_W'(rem_sh);
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule

### design/imac_back.sv
// Moment engine: term products, saturating accumulation, means and result register.
module imac_back import imac_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        mode,
  input  logic [CFG_ORD_W-1:0]        order_row,
  input  logic [CFG_ORD_W-1:0]        order_col,
  input  logic                        q_empty,
  input  pix_item_t                   q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [MOMENT_W-1:0]  out_moment,
  output logic [STATUS_W-1:0]         out_status,
  output logic                        out_first_pass_done
);

  bk_state_t state_r, state_nxt;

  logic                        second_pass_r;
  logic signed [MOMENT_W-1:0]  acc_r;
  logic                        sat_r;
  logic [SUM_G_W-1:0]          sum_grey_r;
  logic [SUM_RC_W-1:0]         sum_row_r;
  logic [SUM_RC_W-1:0]         sum_col_r;
  logic [MEAN_W-1:0]           mean_row_r;
  logic [MEAN_W-1:0]           mean_col_r;

  logic [LIMB_W-1:0]           prod_r [LIMBS];
  logic [LIMB_IDX_W-1:0]       limb_r;
  logic [FAC_W-1:0]            carry_r;
  logic [FAC_W-1:0]            a_mag_r;
  logic [FAC_W-1:0]            b_mag_r;
  logic                        neg_r;
  logic [ORD_W-1:0]            a_left_r;
  logic [ORD_W-1:0]            b_left_r;
  logic [ORD_W:0]              ord_sum_r;
  logic                        last_r;
  logic signed [MOMENT_W-1:0]  term_r;

  logic                        out_valid_r;
  logic signed [MOMENT_W-1:0]  out_moment_r;
  logic [STATUS_W-1:0]         out_status_r;
  logic                        out_fpd_r;

  logic                        div_start;
  logic                        div_sel_col;
  logic                        div_done;
  logic [MEAN_W-1:0]           div_quo;
  logic [DIVD_W-1:0]           div_dividend;
  logic                        emit_load;

  logic [ORD_W-1:0]            p_eff;
  logic [ORD_W-1:0]            q_eff;
  logic [ORD_W:0]              pq_sum;
  logic                        kind_first;
  logic [FAC_W:0]              dev_row;
  logic [FAC_W:0]              dev_col;
  logic [GREY_W+COORD_W-1:0]   grey_row;
  logic [GREY_W+COORD_W-1:0]   grey_col;
  logic [FAC_W-1:0]            factor;
  logic [LIMB_W+FAC_W-1:0]     mac;
  logic                        limb_last;
  logic                        mul_last;
  logic [PROD_BITS-1:0]        prod_flat;
  logic [PROD_BITS-1:0]        prod_shift;
  logic [SH_W-1:0]             shamt;
  logic [MOMENT_W-1:0]         mag;
  logic [MOMENT_W:0]           acc_sum;

  assign p_eff      = eff_order(order_row);
  assign q_eff      = eff_order(order_col);
  assign pq_sum     = (ORD_W+1)'(p_eff) + (ORD_W+1)'(q_eff);
  assign kind_first = mode && !second_pass_r;

  assign dev_row  = ((FAC_W+1)'(q_item.row) << MEAN_FRAC_BITS) - (FAC_W+1)'(mean_row_r);
  assign dev_col  = ((FAC_W+1)'(q_item.col) << MEAN_FRAC_BITS) - (FAC_W+1)'(mean_col_r);
  assign grey_row = (GREY_W+COORD_W)'(q_item.grey) * (GREY_W+COORD_W)'(q_item.row);
  assign grey_col = (GREY_W+COORD_W)'(q_item.grey) * (GREY_W+COORD_W)'(q_item.col);

  // One limb times one factor per cycle
  assign factor    = (a_left_r != '0) ? a_mag_r : b_mag_r;
  assign mac       = (LIMB_W+FAC_W)'(prod_r[limb_r]) * (LIMB_W+FAC_W)'(factor)
                     + (LIMB_W+FAC_W)'(carry_r);
  assign limb_last = (limb_r == LIMB_IDX_W'(LIMBS - 1));
  assign mul_last  = limb_last &&
                     (((ORD_W+1)'(a_left_r) + (ORD_W+1)'(b_left_r)) == (ORD_W+1)'(1));

  always_comb begin
    for (int i = 0; i < LIMBS; i++) begin
      prod_flat[i*LIMB_W +: LIMB_W] = prod_r[i];
    end
  end

  assign shamt      = SH_W'(ord_sum_r) * SH_W'(MEAN_FRAC_BITS);
  assign prod_shift = prod_flat >> shamt;
  assign mag        = (|prod_shift[PROD_BITS-1:MOMENT_W-1]) ? MOM_MAX
                                                             : prod_shift[MOMENT_W-1:0];
  assign acc_sum    = {acc_r[MOMENT_W-1], acc_r} + {term_r[MOMENT_W-1], term_r};

  assign div_dividend = div_sel_col ? (DIVD_W'(sum_col_r) << MEAN_FRAC_BITS)
                                    : (DIVD_W'(sum_row_r) << MEAN_FRAC_BITS);

  imac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum_grey_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    if (clr) begin
      state_nxt = BK_IDLE;
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (!q_empty) begin
            if (kind_first) begin
              state_nxt = q_item.last ? BK_FEND : BK_IDLE;
            end else begin
              state_nxt = (pq_sum == '0) ? BK_SCALE : BK_MUL;
            end
          end
        end
        BK_MUL: begin
          if (mul_last) begin
            state_nxt = BK_SCALE;
          end
        end
        BK_SCALE:   state_nxt = BK_ACC;
        BK_ACC:     state_nxt = last_r ? BK_EMIT : BK_IDLE;
        BK_FEND:    state_nxt = (sum_grey_r == '0) ? BK_EMIT : BK_DIV_ROW;
        BK_DIV_ROW: begin
          if (div_done) begin
            state_nxt = BK_DIV_COL;
          end
        end
        BK_DIV_COL: begin
          if (div_done) begin
            state_nxt = BK_EMIT;
          end
        end
        BK_EMIT: begin
          if (!out_valid_r) begin
            state_nxt = BK_IDLE;
          end
        end
      endcase
    end
  end

  // Control outputs
  always_comb begin
    q_pop       = 1'b0;
    div_start   = 1'b0;
    div_sel_col = 1'b0;
    emit_load   = 1'b0;
    if (!clr) begin
      unique case (state_r)
        BK_IDLE:    q_pop = !q_empty;
        BK_FEND:    div_start = (sum_grey_r != '0);
        BK_DIV_ROW: begin
          div_start   = div_done;
          div_sel_col = 1'b1;
        end
        BK_EMIT:    emit_load = !out_valid_r;
        BK_MUL, BK_SCALE, BK_ACC, BK_DIV_COL: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      second_pass_r <= 1'b0;
      acc_r         <= '0;
      sat_r         <= 1'b0;
      sum_grey_r    <= '0;
      sum_row_r     <= '0;
      sum_col_r     <= '0;
      mean_row_r    <= '0;
      mean_col_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (clr) begin
        second_pass_r <= 1'b0;
        acc_r         <= '0;
        sat_r         <= 1'b0;
        sum_grey_r    <= '0;
        sum_row_r     <= '0;
        sum_col_r     <= '0;
        mean_row_r    <= '0;
        mean_col_r    <= '0;
      end else begin
        unique case (state_r)
          BK_IDLE: begin
            if (q_pop) begin
              last_r <= q_item.last;
              if (kind_first) begin
                sum_grey_r <= sum_grey_r + SUM_G_W'(q_item.grey);
                sum_row_r  <= sum_row_r + SUM_RC_W'(grey_row);
                sum_col_r  <= sum_col_r + SUM_RC_W'(grey_col);
              end else begin
                if (mode) begin
                  a_mag_r   <= dev_row[FAC_W] ? FAC_W'(-dev_row) : FAC_W'(dev_row);
                  b_mag_r   <= dev_col[FAC_W] ? FAC_W'(-dev_col) : FAC_W'(dev_col);
                  neg_r     <= (dev_row[FAC_W] && p_eff[0]) != (dev_col[FAC_W] && q_eff[0]);
                  ord_sum_r <= pq_sum;
                end else begin
                  // raw coordinates are integers: no fraction bits to drop
                  a_mag_r   <= FAC_W'(q_item.row);
                  b_mag_r   <= FAC_W'(q_item.col);
                  neg_r     <= 1'b0;
                  ord_sum_r <= '0;
                end
                for (int i = 0; i < LIMBS; i++) begin
                  prod_r[i] <= (i == 0) ? LIMB_W'(q_item.grey) : '0;
                end
                a_left_r  <= p_eff;
                b_left_r  <= q_eff;
                limb_r    <= '0;
                carry_r   <= '0;
              end
            end
          end
          BK_MUL: begin
            prod_r[limb_r] <= mac[LIMB_W-1:0];
            if (limb_last) begin
              limb_r  <= '0;
              carry_r <= '0;
              if (a_left_r != '0) begin
                a_left_r <= a_left_r - 1'b1;
              end else begin
                b_left_r <= b_left_r - 1'b1;
              end
            end else begin
              limb_r  <= limb_r + 1'b1;
              carry_r <= mac[LIMB_W+FAC_W-1:LIMB_W];
            end
          end
          BK_SCALE: begin
            term_r <= neg_r ? -$signed(mag) : $signed(mag);
            if (|prod_shift[PROD_BITS-1:MOMENT_W-1]) begin
              sat_r <= 1'b1;
            end
          end
          BK_ACC: begin
            if (acc_sum[MOMENT_W] != acc_sum[MOMENT_W-1]) begin
              acc_r <= term_r[MOMENT_W-1] ? MOM_MIN : MOM_MAX;
              sat_r <= 1'b1;
            end else begin
              acc_r <= $signed(acc_sum[MOMENT_W-1:0]);
            end
          end
          BK_FEND: begin
          end
          BK_DIV_ROW: begin
            if (div_done) begin
              mean_row_r <= div_quo;
            end
          end
          BK_DIV_COL: begin
            if (div_done) begin
              mean_col_r <= div_quo;
            end
          end
          BK_EMIT: begin
            if (emit_load) begin
              out_valid_r <= 1'b1;
              acc_r       <= '0;
              sat_r       <= 1'b0;
              if (kind_first) begin
                out_fpd_r <= 1'b1;
                if (sum_grey_r == '0) begin
                  out_moment_r <= '0;
                  out_status_r <= ST_EMPTY;
                end else begin
                  out_moment_r  <= $signed(MOMENT_W'(sum_grey_r));
                  out_status_r  <= ST_OK;
                  second_pass_r <= 1'b1;
                end
                sum_grey_r <= '0;
                sum_row_r  <= '0;
                sum_col_r  <= '0;
              end else begin
                out_fpd_r     <= 1'b0;
                out_moment_r  <= acc_r;
                out_status_r  <= sat_r ? ST_SAT : ST_OK;
                second_pass_r <= 1'b0;
              end
            end
          end
        endcase
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_moment          = out_moment_r;
  assign out_status          = out_status_r;
  assign out_first_pass_done = out_fpd_r;

endmodule

### design/image_moment_accumulator.sv
// Top level of the image moment accumulator: register file, front end, queue, engine.
//
// Usage:
//   Grey pixels stream in raster order on in_valid/in_ready/in_grey; each item
//   gets its row and column from counters sized by image_width/image_height.
//   A result item (out_moment, out_status, out_first_pass_done) leaves on
//   out_valid/out_ready after the last pixel of every pass. In raw mode a pass
//   is one image; in central mode the image is streamed twice, the first pass
//   ending with m00 and first_pass_done set.
//   Engine work: a raw or second-pass pixel is multiplied one 32x18 limb
//   product per cycle over four limbs per power, then scaled and accumulated,
//   before the engine takes the next pixel; a first-pass pixel only adds to the
//   sums. The end of a first pass runs the shared bit-serial divider to form
//   both means. A four-item queue keeps taking pixels while the engine works
//   and while a finished result waits in the output register; when the
//   receiver stalls, the engine holds at the result, then the queue fills and
//   in_ready drops. Reset (rst_n, synchronous) and every write to a known
//   register clear the counters, sums, means and accumulator. Write registers
//   only while the block is idle.
module image_moment_accumulator import imac_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [GREY_W-1:0]           in_grey,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [MOMENT_W-1:0]  out_moment,
  output logic [STATUS_W-1:0]         out_status,
  output logic                        out_first_pass_done,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready
);

  logic                  mode_r;
  logic [CFG_ORD_W-1:0]  order_row_r;
  logic [CFG_ORD_W-1:0]  order_col_r;
  logic [CFG_DIM_W-1:0]  width_r;
  logic [CFG_DIM_W-1:0]  height_r;

  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  clr;

  pix_item_t             push_item;
  pix_item_t             pop_item;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;

  // Register writes land on the access cycle; any known register restarts the image
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];
  assign clr     = wr_en && (reg_idx <= REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      order_row_r <= '0;
      order_col_r <= '0;
      width_r     <= DIM_RESET;
      height_r    <= DIM_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:      mode_r      <= pwdata[0];
        REG_ORDER_ROW: order_row_r <= pwdata[CFG_ORD_W-1:0];
        REG_ORDER_COL: order_col_r <= pwdata[CFG_ORD_W-1:0];
        REG_WIDTH:     width_r     <= pwdata[CFG_DIM_W-1:0];
        REG_HEIGHT:    height_r    <= pwdata[CFG_DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the register file
  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = APB_DW'(mode_r);
      REG_ORDER_ROW: prdata = APB_DW'(order_row_r);
      REG_ORDER_COL: prdata = APB_DW'(order_col_r);
      REG_WIDTH:     prdata = APB_DW'(width_r);
      REG_HEIGHT:    prdata = APB_DW'(height_r);
      default:       prdata = '0;
    endcase
  end

  imac_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .clr          (clr),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_grey      (in_grey),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  imac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  imac_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .clr                 (clr),
    .mode                (mode_r),
    .order_row           (order_row_r),
    .order_col           (order_col_r),
    .q_empty             (q_empty),
    .q_item              (pop_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_moment          (out_moment),
    .out_status          (out_status),
    .out_first_pass_done (out_first_pass_done)
  );

endmodule
